[design/vector_l2_normalizer_unit_defines.svh]
// ---------------------------------------------------------------------------
// vector l2 normalizer assertion macros
// shared property forms for the normalizer checks, clocked on clk, reset rst_n
// ---------------------------------------------------------------------------
`ifndef VECTOR_L2_NORMALIZER_UNIT_DEFINES_SVH
`define VECTOR_L2_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define VLN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vln assertion failed");

// next-cycle implication
`define VLN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vln assertion failed");

`endif

[design/vln_pkg.sv]
// ---------------------------------------------------------------------------
// vln_pkg
// shared widths, defaults and types of the vector l2 normalizer
// ---------------------------------------------------------------------------
`default_nettype none

package vln_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int CNT_W      = 7;
  localparam int ELEM_W     = 16;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 40;
  localparam int NORM_W     = 24;
  localparam int ROOT_W     = 20;
  localparam int GRAD_W     = 32;
  localparam int DIV_W      = 31;
  localparam int FRAC_SH    = 14;
  localparam int ONE_Q14    = 16384;
  localparam int JOBQ_DEPTH = 2;

  // one finished vector handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

  // queue status seen by the top and back
  typedef struct packed {
    logic not_empty;
    logic full;
  } jobq_stat_t;

endpackage

`default_nettype wire

[design/vln_ram.sv]
// ---------------------------------------------------------------------------
// vln_ram
// generic single write, single registered read memory
// ---------------------------------------------------------------------------
`default_nettype none

module vln_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[design/vln_front.sv]
// ---------------------------------------------------------------------------
// vln_front
// stores elements, squares them and accumulates the sum of squares
// ---------------------------------------------------------------------------
`default_nettype none

module vln_front #(
  parameter int VECTOR_DEPTH = vln_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic signed [vln_pkg::ELEM_W-1:0] elem_value,
  input  wire logic                              elem_last,
  output logic                                   ram_we,
  output logic [$clog2(VECTOR_DEPTH)-1:0]        ram_waddr,
  output logic [vln_pkg::ELEM_W-1:0]             ram_wdata,
  output logic                                   job_push,
  output vln_pkg::job_t                          job_data,
  output logic                                   last_pending
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic [vln_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [vln_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [vln_pkg::SQ_W-1:0]  sq_r;
  logic                      sq_v_r, last_r;
  logic                      store;
  logic signed [vln_pkg::SQ_W-1:0] prod;

  // element is kept only while there is room
  assign store     = accept && (count_r < vln_pkg::CNT_W'(VECTOR_DEPTH));
  assign ram_we    = store;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = elem_value;
  assign prod      = elem_value * elem_value;

  // accumulate the registered square
  assign sum_add = sum_r + (sq_v_r ? {{(vln_pkg::SUM_W-vln_pkg::SQ_W){1'b0}}, sq_r}
                                   : {vln_pkg::SUM_W{1'b0}});

  assign job_push       = last_r;
  assign job_data.sum   = sum_add;
  assign job_data.count = count_r;
  assign last_pending   = last_r;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_add;
    if (last_r) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (store) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_v_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_v_r  <= store;
      last_r  <= accept && elem_last;
    end
  end

  // square product register
  always_ff @(posedge clk) begin
    sq_r <= prod;
  end

endmodule

`default_nettype wire

[design/vln_jobq.sv]
// ---------------------------------------------------------------------------
// vln_jobq
// short queue of finished vectors between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module vln_jobq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vln_pkg::job_t push_data,
  input  wire logic          pop,
  output vln_pkg::job_t      pop_data,
  output vln_pkg::jobq_stat_t stat
);

  localparam int PW = $clog2(vln_pkg::JOBQ_DEPTH);

  vln_pkg::job_t  q_r [vln_pkg::JOBQ_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    fill_r;
  logic           do_push, do_pop;

  assign stat.not_empty = (fill_r != '0);
  assign stat.full      = (fill_r == (PW+1)'(vln_pkg::JOBQ_DEPTH));
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign pop_data       = q_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/vln_back.sv]
// ---------------------------------------------------------------------------
// vln_back
// serial square root, then a shared serial divider per element and emission
// ---------------------------------------------------------------------------
`default_nettype none

module vln_back #(
  parameter int VECTOR_DEPTH = vln_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               job_valid,
  input  wire vln_pkg::job_t                      job_data,
  output logic                                    job_pop,
  output logic [$clog2(VECTOR_DEPTH)-1:0]         ram_raddr,
  input  wire logic [vln_pkg::ELEM_W-1:0]         ram_rdata,
  output logic                                    out_valid,
  output logic signed [vln_pkg::ELEM_W-1:0]       out_norm_value,
  output logic signed [vln_pkg::GRAD_W-1:0]       out_grad_value,
  output logic                                    out_zero_norm,
  output logic                                    out_run_last,
  output logic                                    active
);

  localparam int AW  = $clog2(VECTOR_DEPTH);
  localparam int RW  = vln_pkg::SUM_W + 2;
  localparam int DW  = vln_pkg::DIV_W;
  localparam int SW  = $clog2(DW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQRT  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DIV_N = 3'd4;
  localparam logic [2:0] ST_DIV_G = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [vln_pkg::CNT_W-1:0] count_r, count_nxt, k_r, k_nxt;
  logic [RW-1:0]             sqv_r, sqv_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [RW-1:0]             trial;
  logic [vln_pkg::NORM_W-1:0] norm_r, norm_nxt;
  logic [vln_pkg::ROOT_W:0]  rem_r, rem_nxt, rem_sh, den;
  logic [DW-1:0]             quo_r, quo_nxt, quo_sh;
  logic                      neg_r, neg_nxt, ge;
  logic [SW-1:0]             step_r, step_nxt;
  logic signed [vln_pkg::ELEM_W-1:0] nq_sat;
  logic signed [vln_pkg::ELEM_W:0]   d_g;
  logic [vln_pkg::ELEM_W:0]  e_abs;
  logic [vln_pkg::ELEM_W-1:0] dg_abs;
  logic                      is_last;
  logic                      ov_nxt, oz_nxt, ol_nxt;
  logic signed [vln_pkg::ELEM_W-1:0] on_nxt;
  logic signed [vln_pkg::GRAD_W-1:0] og_nxt;
  logic signed [vln_pkg::ELEM_W-1:0] e_s;

  assign active    = (state_r != ST_IDLE);
  assign ram_raddr = k_r[AW-1:0];
  assign is_last   = (k_r == count_r - 1'b1);
  assign e_s       = ram_rdata;

  // one square root step
  assign trial = root_r + bit_r;

  // one restoring divide step
  assign den    = {1'b0, norm_r[vln_pkg::ROOT_W-1:0]};
  assign rem_sh = {rem_r[vln_pkg::ROOT_W-1:0], quo_r[DW-1]};
  assign ge     = (rem_sh >= den);
  assign quo_sh = {quo_r[DW-2:0], ge};

  // magnitude of the element numerator
  assign e_abs = e_s[vln_pkg::ELEM_W-1] ? (vln_pkg::ELEM_W+1)'(-$signed({e_s[vln_pkg::ELEM_W-1], e_s}))
                                        : {1'b0, e_s};

  // normalized value saturated to 16 bits, then gradient numerator
  always_comb begin
    if (neg_r) begin
      if (quo_sh > DW'(32768)) nq_sat = 16'sh8000;
      else nq_sat = vln_pkg::ELEM_W'(-$signed({1'b0, quo_sh}));
    end else begin
      if (quo_sh > DW'(32767)) nq_sat = 16'sh7fff;
      else nq_sat = vln_pkg::ELEM_W'(quo_sh);
    end
  end
  assign d_g    = (vln_pkg::ELEM_W+1)'(vln_pkg::ONE_Q14) - {nq_sat[vln_pkg::ELEM_W-1], nq_sat};
  assign dg_abs = d_g[vln_pkg::ELEM_W] ? vln_pkg::ELEM_W'(-d_g) : d_g[vln_pkg::ELEM_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    sqv_nxt   = sqv_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    norm_nxt  = norm_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_sh;
    neg_nxt   = neg_r;
    step_nxt  = step_r;
    job_pop   = 1'b0;
    ov_nxt    = 1'b0;
    on_nxt    = out_norm_value;
    og_nxt    = out_grad_value;
    oz_nxt    = out_zero_norm;
    ol_nxt    = out_run_last;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          count_nxt = job_data.count;
          sqv_nxt   = RW'(job_data.sum);
          root_nxt  = '0;
          bit_nxt   = RW'(1) << vln_pkg::SUM_W;
          k_nxt     = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqv_r >= trial) begin
          sqv_nxt  = sqv_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == RW'(1)) begin
          norm_nxt  = root_nxt[vln_pkg::NORM_W-1:0];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (norm_r == '0) begin
          ov_nxt = 1'b1;
          on_nxt = '0;
          og_nxt = '0;
          oz_nxt = 1'b1;
          ol_nxt = is_last;
          k_nxt  = k_r + 1'b1;
          state_nxt = is_last ? ST_IDLE : ST_READ;
        end else begin
          quo_nxt   = {e_abs[DW-vln_pkg::FRAC_SH-1:0], {vln_pkg::FRAC_SH{1'b0}}};
          rem_nxt   = '0;
          neg_nxt   = e_s[vln_pkg::ELEM_W-1];
          step_nxt  = SW'(DW-1);
          state_nxt = ST_DIV_N;
        end
      end
      ST_DIV_N: begin
        rem_nxt  = ge ? (rem_sh - den) : rem_sh;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          on_nxt    = nq_sat;
          quo_nxt   = {{(DW-vln_pkg::ELEM_W-vln_pkg::FRAC_SH){1'b0}}, dg_abs,
                       {vln_pkg::FRAC_SH{1'b0}}};
          rem_nxt   = '0;
          neg_nxt   = d_g[vln_pkg::ELEM_W];
          step_nxt  = SW'(DW-1);
          state_nxt = ST_DIV_G;
        end
      end
      ST_DIV_G: begin
        rem_nxt  = ge ? (rem_sh - den) : rem_sh;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          ov_nxt = 1'b1;
          og_nxt = neg_r ? -$signed({1'b0, quo_sh}) : $signed({1'b0, quo_sh});
          oz_nxt = 1'b0;
          ol_nxt = is_last;
          k_nxt  = k_r + 1'b1;
          state_nxt = is_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    count_r        <= count_nxt;
    k_r            <= k_nxt;
    sqv_r          <= sqv_nxt;
    root_r         <= root_nxt;
    bit_r          <= bit_nxt;
    norm_r         <= norm_nxt;
    rem_r          <= rem_nxt;
    quo_r          <= quo_nxt;
    neg_r          <= neg_nxt;
    step_r         <= step_nxt;
    out_norm_value <= on_nxt;
    out_grad_value <= og_nxt;
    out_zero_norm  <= oz_nxt;
    out_run_last   <= ol_nxt;
  end

endmodule

`default_nettype wire

[design/vector_l2_normalizer_unit.sv]
// ---------------------------------------------------------------------------
// vector_l2_normalizer_unit
// l2 normalization of a vector with gradient, fixed point
// ---------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  input    | in_elem_value, in_elem_last             | start && !busy
//  result   | out_norm_value, out_grad_value,         | out_valid, one cycle
//           | out_zero_norm, out_run_last             |
//
// an element without the last flag leaves busy low, so the next one can follow
// after the last element: a handoff through the queue, a serial square root,
// then per element a memory read, a wait state for the read data and two
// 31-step divides
// zero norm skips the divides: only the read and the wait state per element
// rst_n is synchronous; the result side has no stall
// ---------------------------------------------------------------------------
`default_nettype none

`include "vector_l2_normalizer_unit_defines.svh"

module vector_l2_normalizer_unit #(
  parameter int VECTOR_DEPTH = vln_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [vln_pkg::ELEM_W-1:0]  in_elem_value,
  input  wire logic                               in_elem_last,
  output logic                                    out_valid,
  output logic signed [vln_pkg::ELEM_W-1:0]       out_norm_value,
  output logic signed [vln_pkg::GRAD_W-1:0]       out_grad_value,
  output logic                                    out_zero_norm,
  output logic                                    out_run_last
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic                        accept;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [vln_pkg::ELEM_W-1:0]  ram_wdata, ram_rdata;
  logic                        job_push, job_pop, last_pending, back_active;
  vln_pkg::job_t               push_job, pop_job;
  vln_pkg::jobq_stat_t         q_stat;

  // item handshake
  assign busy   = last_pending || q_stat.not_empty || back_active;
  assign accept = start && !busy;

  vln_front #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .elem_value   (in_elem_value),
    .elem_last    (in_elem_last),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .job_push     (job_push),
    .job_data     (push_job),
    .last_pending (last_pending)
  );

  vln_ram #(.WIDTH(vln_pkg::ELEM_W), .DEPTH(VECTOR_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vln_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .pop       (job_pop),
    .pop_data  (pop_job),
    .stat      (q_stat)
  );

  vln_back #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_stat.not_empty),
    .job_data       (pop_job),
    .job_pop        (job_pop),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_norm_value (out_norm_value),
    .out_grad_value (out_grad_value),
    .out_zero_norm  (out_zero_norm),
    .out_run_last   (out_run_last),
    .active         (back_active)
  );

  // checks
  `VLN_ASSERT_NXT(a_last_makes_busy, accept && in_elem_last, busy)
  `VLN_ASSERT_IMP(a_zero_norm_out, out_valid && out_zero_norm, (out_norm_value == '0) && (out_grad_value == '0))
  `VLN_ASSERT_NXT(a_last_result_ends, out_valid && out_run_last, !out_valid)

endmodule

`default_nettype wire
